// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/sdpt_pkg.sv =====
`default_nettype none

package sdpt_pkg;

  // fixed slot count of the result record
  localparam int SW_SLOTS = 3;
  localparam int CNT_W    = 8;
  localparam int TIME_W   = 32;

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;
  localparam int DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;

  localparam logic [CNT_W-1:0] DEFAULT_DEBOUNCE = 8'd10;

  typedef struct packed {
    logic [SW_SLOTS-1:0] pin_levels;
    logic [TIME_W-1:0]   now_ms;
    logic [SW_SLOTS-1:0] click_ack;
  } in_item_t;

  typedef struct packed {
    logic [SW_SLOTS-1:0] pressed_mask;
    logic [TIME_W-1:0]   held_ms_a;
    logic [TIME_W-1:0]   held_ms_b;
    logic [TIME_W-1:0]   held_ms_c;
    logic [TIME_W-1:0]   click_ms_a;
    logic [TIME_W-1:0]   click_ms_b;
    logic [TIME_W-1:0]   click_ms_c;
  } out_item_t;

  // per-switch control from the top level
  typedef struct packed {
    logic upd;
    logic pin;
    logic ack;
  } lane_ctl_t;

  // per-switch status after the update
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] held_ms;
    logic [TIME_W-1:0] click_ms;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdpt_lane.sv =====
`default_nettype none

module sdpt_lane
  import sdpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lane_ctl_t         ctl,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [CNT_W-1:0]  debounce,
  output lane_res_t              res
);

  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic              pressed_r, pressed_nxt;
  logic [TIME_W-1:0] stamp_r,   stamp_nxt;
  logic [TIME_W-1:0] click_r,   click_nxt;
  logic [TIME_W-1:0] click_acked;
  logic [TIME_W-1:0] diff;
  logic              press, release_ev;

  always_comb begin
    // low pin reloads, high pin counts down to zero
    if (ctl.pin) begin
      cnt_nxt = (cnt_r != '0) ? cnt_r - CNT_W'(1) : '0;
    end else begin
      cnt_nxt = debounce;
    end

    click_acked = ctl.ack ? '0 : click_r;
    diff        = now_ms - stamp_r;
    release_ev  = pressed_r && (cnt_nxt == '0);
    press       = !pressed_r && (cnt_nxt != '0);

    pressed_nxt = pressed_r;
    click_nxt   = click_acked;
    stamp_nxt   = stamp_r;
    if (release_ev) begin
      pressed_nxt = 1'b0;
      click_nxt   = diff;
      stamp_nxt   = now_ms;
    end else if (press) begin
      pressed_nxt = 1'b1;
      click_nxt   = '0;
      stamp_nxt   = now_ms;
    end

    res.pressed  = pressed_nxt;
    // a fresh press is stamped now, so it has been held for zero
    res.held_ms  = (pressed_nxt && !press) ? diff : '0;
    res.click_ms = click_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      pressed_r <= 1'b0;
      stamp_r   <= '0;
      click_r   <= '0;
    end else if (ctl.upd) begin
      cnt_r     <= cnt_nxt;
      pressed_r <= pressed_nxt;
      stamp_r   <= stamp_nxt;
      click_r   <= click_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/switch_debounce_press_timer_top.sv =====
`default_nettype none

// Debounces up to three active-low switches and times their presses. Each request
// is one sample tick carrying the pin levels, the current millisecond time and a
// mask that acknowledges pending click lengths. A press counts on the first low
// sample; a release counts once the switch has read high for release_debounce_count
// samples in a row (register 0 at byte address 0, reset value 10; a value of 0
// blocks presses). Each tick yields one result: the pressed mask, how long each
// switch has been held (0 when released) and the last completed press length of
// each switch (0 once acknowledged). Times wrap modulo 2^32. One request is taken
// every clock cycle unless the result register stalls; a request is held in the
// input register and its result is then captured in the result register. The
// input register holds its request while a finished result waits for out_ready,
// so a new request is then taken only if the input register is empty. Switch
// slots at or above NUM_SWITCHES report all zeros and ignore their input bits.
// Configuration must only be written while the block is idle.

module switch_debounce_press_timer_top
  import sdpt_pkg::*;
#(
  parameter int NUM_SWITCHES = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // sample tick requests
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  // results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // input register
  logic      s1_valid_r;
  in_item_t  s1_item_r;

  // result register
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic [CNT_W-1:0]     debounce_r;
  logic                 advance;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  lane_ctl_t lane_ctl [SW_SLOTS];
  lane_res_t lane_res [SW_SLOTS];

  // the request moves into the result register when that one is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // register port: no wait states, index from the word address
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_DEBOUNCE);

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DEBOUNCE) begin
      prdata = DATA_W'(debounce_r);
    end
  end

  // one lane per present switch, the rest tie off to zero
  for (genvar g = 0; g < SW_SLOTS; g++) begin : g_slot
    if (g < NUM_SWITCHES) begin : g_lane
      assign lane_ctl[g] = '{upd: advance,
                             pin: s1_item_r.pin_levels[g],
                             ack: s1_item_r.click_ack[g]};
      sdpt_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl[g]),
        .now_ms   (s1_item_r.now_ms),
        .debounce (debounce_r),
        .res      (lane_res[g])
      );
    end else begin : g_absent
      assign lane_ctl[g] = '0;
      assign lane_res[g] = '0;
    end
  end

  // pack lane status into the result record
  always_comb begin
    out_item_nxt.pressed_mask = {lane_res[2].pressed, lane_res[1].pressed,
                                 lane_res[0].pressed};
    out_item_nxt.held_ms_a    = lane_res[0].held_ms;
    out_item_nxt.held_ms_b    = lane_res[1].held_ms;
    out_item_nxt.held_ms_c    = lane_res[2].held_ms;
    out_item_nxt.click_ms_a   = lane_res[0].click_ms;
    out_item_nxt.click_ms_b   = lane_res[1].click_ms;
    out_item_nxt.click_ms_c   = lane_res[2].click_ms;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      debounce_r  <= DEFAULT_DEBOUNCE;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        debounce_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sdpt_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module sdpt_checker
  import sdpt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a waiting request holds still
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_data))

  // a waiting result holds still
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // with the result register empty the block always takes a request
  `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  // a released switch a or b reports no hold time
  `ASSERT_SAME(a_held_a_zero, clk, rst_n, out_valid && !out_data.pressed_mask[0],
               out_data.held_ms_a == '0)

  `ASSERT_SAME(a_held_b_zero, clk, rst_n, out_valid && !out_data.pressed_mask[1],
               out_data.held_ms_b == '0)

endmodule

bind switch_debounce_press_timer_top sdpt_checker u_sdpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
